// ===== src/assert_macros.svh =====
// Assertion macros shared by the RTL files of the token estimator.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("assertion failure");
// Condition must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  `ASSERT_PROP(lbl, clk, rst_n, !(cond))
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

// ===== src/ute_pkg.sv =====
// Types, constants and byte classification for the UTF-8 token estimator.
// No dependencies; used by the interfaces, ute_step and the top level.
`default_nettype none

package ute_pkg;

  localparam int unsigned CountWidth = 31;

  typedef logic [CountWidth-1:0] count_t;
  typedef logic [7:0]            byte_t;

  localparam byte_t ContMask  = 8'hC0;
  localparam byte_t ContCode  = 8'h80;
  localparam byte_t Lead2Mask = 8'hE0;
  localparam byte_t Lead2Code = 8'hC0;
  localparam byte_t Lead3Mask = 8'hF0;
  localparam byte_t Lead3Code = 8'hE0;
  localparam byte_t Lead4Mask = 8'hF8;
  localparam byte_t Lead4Code = 8'hF0;

  localparam logic [1:0] AsciiGroupLast = 2'd2;  // phase wraps after this (run of 3)

  typedef enum logic [2:0] {
    BC_ASCII,
    BC_CONT,
    BC_LEAD2,
    BC_LEAD3,
    BC_LEAD4,
    BC_LONE
  } byte_class_e;

  // Decoder state carried between bytes of one text.
  typedef struct packed {
    logic [1:0] phase;   // position in ASCII run, mod 3
    logic [2:0] width;   // open sequence width, 0 = none
    logic [2:0] taken;   // bytes of open sequence taken
  } ute_state_t;

  function automatic byte_class_e classify(byte_t b);
    byte_class_e c;
    if (b[7] == 1'b0)                       c = BC_ASCII;
    else if ((b & ContMask) == ContCode)    c = BC_CONT;
    else if ((b & Lead2Mask) == Lead2Code)  c = BC_LEAD2;
    else if ((b & Lead3Mask) == Lead3Code)  c = BC_LEAD3;
    else if ((b & Lead4Mask) == Lead4Code)  c = BC_LEAD4;
    else                                    c = BC_LONE;
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== src/ute_if.sv =====
// Valid/ready channel interfaces of the token estimator.
// Depends on ute_pkg for the count type.
`default_nettype none

interface ute_in_if;
  logic                 valid;
  logic                 ready;
  ute_pkg::byte_t       data_byte;
  logic                 byte_present;
  logic                 end_of_text;

  modport source (output valid, data_byte, byte_present, end_of_text, input ready);
  modport sink   (input valid, data_byte, byte_present, end_of_text, output ready);
endinterface

interface ute_out_if;
  logic                 valid;
  logic                 ready;
  ute_pkg::count_t      token_count;

  modport source (output valid, token_count, input ready);
  modport sink   (input valid, token_count, output ready);
endinterface

`default_nettype wire

// ===== src/ute_step.sv =====
// One-byte decoder step: next decoder state, tokens to add, result flag.
// Depends on ute_pkg.
`default_nettype none

module ute_step (
  input  ute_pkg::ute_state_t state_i,
  input  ute_pkg::byte_t      data_byte_i,
  input  logic                byte_present_i,
  input  logic                end_of_text_i,
  output ute_pkg::ute_state_t state_o,
  output logic [2:0]          add_o,    // at most 4 tokens per byte
  output logic                emit_o
);
  import ute_pkg::*;

  byte_class_e cls;
  ute_state_t  st;
  logic [2:0]  add;
  logic [2:0]  taken_inc;
  logic        fresh;

  assign cls       = classify(data_byte_i);
  assign taken_inc = state_i.taken + 3'd1;

  always_comb begin
    st    = state_i;
    add   = 3'd0;
    fresh = 1'b0;

    if (byte_present_i) begin
      if (st.width != 3'd0 && cls == BC_CONT) begin
        if (taken_inc >= st.width) begin
          add      = (st.width == 3'd4) ? 3'd2 : 3'd1;
          st.width = 3'd0;
          st.taken = 3'd0;
        end else begin
          st.taken = taken_inc;
        end
      end else begin
        // broken sequence: charge the bytes taken, then decode afresh
        if (st.width != 3'd0) begin
          add      = st.taken;
          st.width = 3'd0;
          st.taken = 3'd0;
        end
        fresh = 1'b1;
      end
    end

    if (fresh) begin
      unique case (cls)
        BC_ASCII: begin
          if (st.phase == 2'd0) add = add + 3'd1;
          st.phase = (st.phase >= AsciiGroupLast) ? 2'd0 : st.phase + 2'd1;
        end
        BC_LEAD2: begin
          st.phase = 2'd0; st.width = 3'd2; st.taken = 3'd1;
        end
        BC_LEAD3: begin
          st.phase = 2'd0; st.width = 3'd3; st.taken = 3'd1;
        end
        BC_LEAD4: begin
          st.phase = 2'd0; st.width = 3'd4; st.taken = 3'd1;
        end
        default: begin  // lone continuation or invalid lead
          st.phase = 2'd0;
          add      = add + 3'd1;
        end
      endcase
    end

    if (end_of_text_i) begin
      if (st.width != 3'd0) add = add + st.taken;  // cut-off sequence
      st = '0;
    end
  end

  assign state_o = st;
  assign add_o   = add;
  assign emit_o  = end_of_text_i;

endmodule

`default_nettype wire

// ===== src/utf8_token_estimator_core.sv =====
// UTF-8 token estimator, top level: input register, decoder step, result register.
// Depends on ute_pkg, ute_if (ute_in_if, ute_out_if), ute_step and assert_macros.svh.
//
// Usage:
//   in_i  : one transfer per text byte (data_byte, byte_present) with end_of_text
//           set on the last item. A bare item (byte_present = 0) may carry the end.
//   out_o : one transfer per finished text, carrying the saturated token_count.
//   Order: an item taken into the input register is decoded when that register
//   advances (see Stall); its result, if any, then sits in the output register.
//   Throughput: one item per cycle unless an end-of-text item holds; the decoder
//   state update is one step (classify, small add, saturating add on the total).
//   Stall: non-final items keep flowing while a result waits on out_o. Only an
//   end-of-text item that would overwrite an untaken result holds in the input
//   register, and in_i.ready drops until out_o.ready frees the slot.
//   Reset: rst_ni clears both valid flags, the decoder state and the total; the
//   first item after reset starts a new text. Each result also clears the state.
`default_nettype none
`include "assert_macros.svh"

module utf8_token_estimator_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  ute_in_if.sink    in_i,
  ute_out_if.source out_o
);
  import ute_pkg::*;

  // input register
  logic       s1_valid_q;
  byte_t      s1_byte_q;
  logic       s1_present_q;
  logic       s1_end_q;
  logic       s1_adv;
  logic       in_xfer;

  // decoder state
  ute_state_t state_q, state_d;
  count_t     total_q, total_d;
  count_t     total_sat;
  logic [CountWidth:0] total_sum;
  logic [2:0] add;
  logic       emit;

  // result register
  logic       out_valid_q;
  count_t     out_count_q;

  // The stage advances unless it holds a result and the output slot is still occupied.
  assign s1_adv  = s1_valid_q && !(s1_end_q && out_valid_q && !out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_adv;
  assign in_xfer = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_byte_q    <= in_i.data_byte;
      s1_present_q <= in_i.byte_present;
      s1_end_q     <= in_i.end_of_text;
    end
  end

  ute_step u_step (
    .state_i        (state_q),
    .data_byte_i    (s1_byte_q),
    .byte_present_i (s1_present_q),
    .end_of_text_i  (s1_end_q),
    .state_o        (state_d),
    .add_o          (add),
    .emit_o         (emit)
  );

  // Saturating add: all tokens of one byte are summed first, then clamped once.
  assign total_sum = {1'b0, total_q} + {{(CountWidth-2){1'b0}}, add};
  assign total_sat = total_sum[CountWidth] ? '1 : total_sum[CountWidth-1:0];
  assign total_d   = emit ? '0 : total_sat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
      total_q <= '0;
    end else if (s1_adv) begin
      state_q <= state_d;
      total_q <= total_d;
    end
  end

  // Output register; a new result may replace one taken in the same cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv && emit) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && emit) begin
      out_count_q <= total_sat;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.token_count = out_count_q;

  // An open sequence has taken at least its lead and fewer bytes than its width.
  `ASSERT_PROP(a_taken_range, clk_i, rst_ni,
               (state_q.width != 3'd0) |-> (state_q.taken != 3'd0 && state_q.taken < state_q.width))
  `ASSERT_PROP(a_taken_idle, clk_i, rst_ni, (state_q.width == 3'd0) |-> (state_q.taken == 3'd0))
  `ASSERT_NEVER(a_phase_range, clk_i, rst_ni, state_q.phase > AsciiGroupLast)
  `ASSERT_PROP(a_seq_ends_run, clk_i, rst_ni, (state_q.width != 3'd0) |-> (state_q.phase == 2'd0))
  `ASSERT_PROP(a_clear_after_end, clk_i, rst_ni,
               (s1_adv && s1_end_q) |=> (total_q == '0 && state_q == '0 && out_valid_q))

endmodule

`default_nettype wire

// ===== tb/sv/ute_count_checker.sv =====
// Scoreboard for the UTF-8 token estimator: predicts the token count of each text and
// checks the out_o transfers against it. Depends on ute_pkg for widths and byte codes.
`timescale 1ns / 100ps

module ute_count_checker (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            in_ready_i,
  input  ute_pkg::byte_t  in_data_byte_i,
  input  logic            in_byte_present_i,
  input  logic            in_end_of_text_i,
  input  logic            out_valid_i,
  input  logic            out_ready_i,
  input  ute_pkg::count_t out_token_count_i,
  output int              fail_count_o,
  output int              pending_o
);
  import ute_pkg::*;

  localparam count_t CountMax = '1;

  // decoder state of the text in progress
  logic [1:0] run_phase;
  logic [2:0] seq_width;
  logic [2:0] seq_taken;
  count_t     text_total;

  count_t     count_q[$];
  int         fail_count;

  assign fail_count_o = fail_count;
  assign pending_o    = count_q.size();

  function automatic count_t sat_add(count_t a, int unsigned n);
    logic [CountWidth:0] s;
    s = {1'b0, a} + (CountWidth + 1)'(n);
    return s[CountWidth] ? CountMax : s[CountWidth-1:0];
  endfunction

  task automatic report_mismatch(string what, count_t got, count_t want);
    $display("%0t ns: %s: token_count got %0d, want %0d", $time, what, got, want);
    fail_count++;
  endtask

  // one byte of text: continue or break an open sequence, else decode afresh
  task automatic absorb_byte(byte_t b);
    if (seq_width != 3'd0) begin
      if ((b & ContMask) == ContCode) begin
        seq_taken = seq_taken + 3'd1;
        if (seq_taken >= seq_width) begin
          text_total = sat_add(text_total, (seq_width == 3'd4) ? 2 : 1);
          seq_width  = 3'd0;
          seq_taken  = 3'd0;
        end
        return;
      end
      text_total = sat_add(text_total, seq_taken);
      seq_width  = 3'd0;
      seq_taken  = 3'd0;
    end
    if (!b[7]) begin
      if (run_phase == 2'd0) text_total = sat_add(text_total, 1);
      run_phase = (run_phase >= AsciiGroupLast) ? 2'd0 : run_phase + 2'd1;
    end else begin
      run_phase = 2'd0;
      if ((b & Lead2Mask) == Lead2Code)      seq_width = 3'd2;
      else if ((b & Lead3Mask) == Lead3Code) seq_width = 3'd3;
      else if ((b & Lead4Mask) == Lead4Code) seq_width = 3'd4;
      if (seq_width != 3'd0) seq_taken = 3'd1;
      else                   text_total = sat_add(text_total, 1);
    end
  endtask

  task automatic clear_text();
    run_phase  = 2'd0;
    seq_width  = 3'd0;
    seq_taken  = 3'd0;
    text_total = '0;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_text();
      count_q.delete();
      fail_count = 0;
    end else begin
      // result side first: an item taken at this edge cannot have produced it yet
      if (out_valid_i && out_ready_i) begin
        if (count_q.size() == 0) begin
          report_mismatch("unexpected result", out_token_count_i, '0);
        end else begin
          if (out_token_count_i !== count_q[0])
            report_mismatch("wrong count", out_token_count_i, count_q[0]);
          void'(count_q.pop_front());
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (in_byte_present_i) absorb_byte(in_data_byte_i);
        if (in_end_of_text_i) begin
          if (seq_width != 3'd0) text_total = sat_add(text_total, seq_taken);
          count_q.push_back(text_total);
          clear_text();
        end
      end
    end
  end

endmodule

// ===== tb/sv/utf8_token_estimator_core_tb.sv =====
// Testbench top for utf8_token_estimator_core: byte stimulus, output back-pressure, verdict.
// Depends on ute_pkg, ute_in_if / ute_out_if, the core and ute_count_checker.
`timescale 1ns / 100ps

module utf8_token_estimator_core_tb;
  import ute_pkg::*;

  localparam int RandomItems  = 400;
  localparam int RxHoldCycles = 120;     // long receiver hold-off, fills the core
  localparam int TailCycles   = 8;       // wait for stray results before the verdict
  localparam int LimitNs      = 2000000; // far above the slowest correct run

  // one transfer on in_i
  typedef struct {
    byte_t b;
    bit    present;
    bit    last;
  } text_item_t;

  logic clk;
  logic rst_n;

  ute_in_if  in_bus ();
  ute_out_if out_bus ();

  int fail_count;
  int pending;

  // idle rates in percent, changed between phases
  int tx_idle_pct;
  int rx_idle_pct;
  // bumped by the stimulus to ask the receiver for one long hold-off
  int hold_req;
  // items sent that carry a byte or the end (bare non-final items do not count)
  int items_sent;

  utf8_token_estimator_core u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_bus.sink),
    .out_o  (out_bus.source)
  );

  ute_count_checker u_checker (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_bus.valid),
    .in_ready_i        (in_bus.ready),
    .in_data_byte_i    (in_bus.data_byte),
    .in_byte_present_i (in_bus.byte_present),
    .in_end_of_text_i  (in_bus.end_of_text),
    .out_valid_i       (out_bus.valid),
    .out_ready_i       (out_bus.ready),
    .out_token_count_i (out_bus.token_count),
    .fail_count_o      (fail_count),
    .pending_o         (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run here.
  initial begin
    #LimitNs;
    $display("CHECKS FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver: random ready, plus one long hold-off on request. The hold is
  // counted here so the sender keeps offering items the whole time; the core
  // must then park the next end-of-text item and drop in_i.ready.
  // ---------------------------------------------------------------------------
  initial begin
    int hold_left;
    int seen_req;
    hold_left = 0;
    seen_req  = 0;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req != seen_req) begin
        seen_req  = hold_req;
        hold_left = RxHoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------

  // Offer one item and return at the edge where its transfer happens. valid and
  // ready are read right after the edge, i.e. their pre-edge values.
  task automatic send_item(byte_t b, bit present, bit last);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid        <= 1'b1;
    in_bus.data_byte    <= b;
    in_bus.byte_present <= present;
    in_bus.end_of_text  <= last;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    if (present || last) items_sent++;
  endtask

  // Pause until every predicted count has been taken off out_o. The checker
  // updates its queue at the edge, so the count is read at the falling edge.
  task automatic wait_for_counts();
    in_bus.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    @(posedge clk);
  endtask

  function automatic byte_t lead_byte(int w);
    byte_t r;
    r = byte_t'($urandom);
    case (w)
      2:       return Lead2Code | (r & ~Lead2Mask);
      3:       return Lead3Code | (r & ~Lead3Mask);
      default: return Lead4Code | (r & ~Lead4Mask);
    endcase
  endfunction

  function automatic byte_t cont_byte();
    return ContCode | (byte_t'($urandom) & ~ContMask);
  endfunction

  // One random text: mostly runs of ASCII and well-formed sequences, with lone
  // bytes, sequences broken or cut off, bare items and raw noise mixed in.
  task automatic send_random_text();
    text_item_t items[$];
    int n_segs;
    int kind;
    int w;
    int k;
    n_segs = $urandom_range(1, 6);
    repeat (n_segs) begin
      kind = $urandom_range(99);
      if (kind < 35) begin
        repeat ($urandom_range(1, 7)) items.push_back('{byte_t'($urandom_range(0, 127)), 1, 0});
      end else if (kind < 60) begin
        w = $urandom_range(2, 4);
        items.push_back('{lead_byte(w), 1, 0});
        repeat (w - 1) items.push_back('{cont_byte(), 1, 0});
      end else if (kind < 70) begin
        // continuation without a lead, or a byte that can never lead
        if ($urandom_range(1)) items.push_back('{cont_byte(), 1, 0});
        else items.push_back('{byte_t'($urandom_range(8'hF8, 8'hFF)), 1, 0});
      end else if (kind < 85) begin
        // sequence short of its width; a later non-continuation byte or the end breaks it
        w = $urandom_range(2, 4);
        k = $urandom_range(0, w - 2);
        items.push_back('{lead_byte(w), 1, 0});
        repeat (k) items.push_back('{cont_byte(), 1, 0});
      end else if (kind < 92) begin
        items.push_back('{byte_t'($urandom), 0, 0});
      end else begin
        repeat ($urandom_range(1, 3)) items.push_back('{byte_t'($urandom), 1, 0});
      end
    end
    // end on the last byte, or on a bare end marker
    if (!items[$].present || $urandom_range(1)) items.push_back('{byte_t'($urandom), 0, 1});
    else items[$].last = 1'b1;
    foreach (items[i]) send_item(items[i].b, items[i].present, items[i].last);
  endtask

  // ---------------------------------------------------------------------------
  // Main stimulus
  // ---------------------------------------------------------------------------
  initial begin
    int phase_end;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_req    = 0;
    items_sent  = 0;
    rst_n       = 1'b0;
    in_bus.valid        <= 1'b0;
    in_bus.data_byte    <= '0;
    in_bus.byte_present <= 1'b0;
    in_bus.end_of_text  <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    tx_idle_pct = 35;
    rx_idle_pct = 56;

    // Directed texts.
    // Byte extremes: 0x00 alone, then an ASCII run of four (two tokens).
    send_item(8'h00, 1, 1);
    send_item(8'h7F, 1, 0);
    send_item(8'h41, 1, 0);
    send_item(8'h42, 1, 0);
    send_item(8'h43, 1, 1);
    // Lone bytes split ASCII runs: each ASCII byte after them opens a new run.
    send_item(8'h78, 1, 0);
    send_item(8'h80, 1, 0);
    send_item(8'h79, 1, 0);
    send_item(8'hFF, 1, 0);
    send_item(8'hF8, 1, 1);
    // Well-formed 2-, 3- and 4-byte sequences, text closed by a bare end.
    send_item(8'hC3, 1, 0);
    send_item(8'hA9, 1, 0);
    send_item(8'hE2, 1, 0);
    send_item(8'h82, 1, 0);
    send_item(8'hAC, 1, 0);
    send_item(8'hF0, 1, 0);
    send_item(8'h9F, 1, 0);
    send_item(8'h98, 1, 0);
    send_item(8'h80, 1, 0);
    send_item(8'h00, 0, 1);
    // Sequence broken by an ASCII byte, then one cut off by the end.
    send_item(8'hE2, 1, 0);
    send_item(8'h82, 1, 0);
    send_item(8'h61, 1, 0);
    send_item(8'hF0, 1, 0);
    send_item(8'h9F, 1, 1);
    // Bare item that carries nothing, then an empty text.
    send_item(8'hFF, 0, 0);
    send_item(8'h00, 0, 1);
    wait_for_counts();

    // Random texts in three idling phases.
    items_sent = 0;
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          tx_idle_pct = 35;
          rx_idle_pct = 56;
        end
        1: begin
          tx_idle_pct = 56;
          rx_idle_pct = 35;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
          hold_req++;
        end
      endcase
      phase_end = (ph == 2) ? RandomItems : (ph + 1) * RandomItems / 3;
      while (items_sent < phase_end) send_random_text();
      wait_for_counts();
    end

    // Let any stray result show up before the verdict.
    repeat (TailCycles) @(posedge clk);
    @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/ute_pkg.sv
src/ute_if.sv
src/ute_step.sv
src/utf8_token_estimator_core.sv
tb/sv/ute_count_checker.sv
tb/sv/utf8_token_estimator_core_tb.sv
